@@ sv/gcd_pkg.sv @@
`timescale 1ns / 1ps

package gcd_pkg;

    // Width of the operand and result ports.
    localparam int OPERAND_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new operand pair
        logic step;    // perform one binary reduction step
        logic finish;  // register the divisor into the result register
    } gcd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reduced; // one of the working values has reached zero
    } gcd_status_t;

endpackage

@@ sv/euclid_gcd.sv @@
`timescale 1ns / 1ps

// Greatest common divisor of two unsigned operands.
// Input channel: drive operand_a and operand_b and raise start; the
// transaction is taken at the rising edge where start is high and busy is low.
// Operands are reduced modulo 2^WIDTH before use.
// Output channel: done pulses for exactly one cycle with the divisor on
// divisor_out; the receiver cannot stall, so the result must be taken then.
// divisor_out holds its value until the next result is written.
// A zero operand yields the other operand; two zeros yield zero.
// The binary reduction loop runs one shift or subtract-and-shift step per
// cycle until a working value is zero; then the result register is written
// and done is raised together with the new value on divisor_out.
// busy is high only while the loop runs; a new transaction may be started
// in the cycle where done is high, so items follow at the loop's pace.
// Reset (rst_n, asynchronous, active low) returns the controller to idle;
// no result is pending after reset.
module euclid_gcd #(
    parameter int WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [gcd_pkg::OPERAND_W-1:0] operand_a,
    input  logic [gcd_pkg::OPERAND_W-1:0] operand_b,
    output logic                          done,
    output logic [gcd_pkg::OPERAND_W-1:0] divisor_out
);
    import gcd_pkg::*;

    gcd_cmd_t    cmd;
    gcd_status_t status;

    // Sequencer for load, reduction steps and result capture.
    gcd_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Working registers, reduction step and result register.
    gcd_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .status      (status),
        .divisor_out (divisor_out)
    );

endmodule

@@ sv/gcd_datapath.sv @@
`timescale 1ns / 1ps

module gcd_datapath #(
    parameter int WIDTH = 32
) (
    input  logic                                clk,
    input  gcd_pkg::gcd_cmd_t                   cmd,
    input  logic [gcd_pkg::OPERAND_W-1:0]       operand_a,
    input  logic [gcd_pkg::OPERAND_W-1:0]       operand_b,
    output gcd_pkg::gcd_status_t                status,
    output logic [gcd_pkg::OPERAND_W-1:0]       divisor_out
);
    import gcd_pkg::*;

    localparam int KW = $clog2(WIDTH);

    logic [WIDTH-1:0] a_in;
    logic [WIDTH-1:0] b_in;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] a_next;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] b_next;
    logic [KW-1:0]    k_reg;
    logic [KW-1:0]    k_next;
    logic [WIDTH-1:0] result_reg;
    logic [WIDTH-1:0] result_next;
    logic [WIDTH-1:0] diff_ab;
    logic [WIDTH-1:0] diff_ba;
    logic             a_ge_b;

    // Bring the port operands to the datapath width.
    generate
        if (WIDTH <= OPERAND_W) begin : g_narrow
            assign a_in        = operand_a[WIDTH-1:0];
            assign b_in        = operand_b[WIDTH-1:0];
            assign divisor_out = {{(OPERAND_W-WIDTH){1'b0}}, result_reg};
        end else begin : g_wide
            assign a_in        = {{(WIDTH-OPERAND_W){1'b0}}, operand_a};
            assign b_in        = {{(WIDTH-OPERAND_W){1'b0}}, operand_b};
            assign divisor_out = result_reg[OPERAND_W-1:0];
        end
    endgenerate

    // Subtractors and compare for the odd/odd step.
    assign diff_ab = a_reg - b_reg;
    assign diff_ba = b_reg - a_reg;
    assign a_ge_b  = (a_reg >= b_reg);

    // The reduction is over once either working value is zero.
    assign status.reduced = (a_reg == '0) || (b_reg == '0);

    // One binary reduction step: strip common twos, strip lone twos,
    // or subtract the smaller odd value from the larger and halve.
    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        result_next = result_reg;
        if (cmd.load)
        begin
            a_next = a_in;
            b_next = b_in;
            k_next = '0;
        end
        else if (cmd.step)
        begin
            if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_ge_b)
            begin
                a_next = diff_ab >> 1;
            end
            else
            begin
                b_next = diff_ba >> 1;
            end
        end
        if (cmd.finish)
        begin
            // The nonzero value restored by the common power of two.
            result_next = (a_reg | b_reg) << k_reg;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        result_reg <= result_next;
    end

endmodule

@@ sv/gcd_controller.sv @@
`timescale 1ns / 1ps

module gcd_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  gcd_pkg::gcd_status_t status,
    output gcd_pkg::gcd_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import gcd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A transaction is taken whenever the reduction loop is free.
    assign accept = start && !busy;
    assign busy   = (state_reg == S_RUN);
    assign done   = (state_reg == S_DONE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            S_IDLE, S_DONE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RUN:
            begin
                if (status.reduced)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/gcd_checker.sv @@
`timescale 1ns / 1ps

module gcd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [gcd_pkg::OPERAND_W-1:0] operand_a,
    input logic [gcd_pkg::OPERAND_W-1:0] operand_b,
    input logic                          done,
    input logic [gcd_pkg::OPERAND_W-1:0] divisor_out
);

    // An accepted transaction keeps the loop busy in the next cycle.
    property p_accept_busy;
        @(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy;
    endproperty
    a_accept_busy: assert property (p_accept_busy)
        else $error("loop not busy after an accepted transaction");

    // The result strobe never overlaps a running reduction.
    property p_done_idle;
        @(posedge clk) disable iff (!rst_n) done |-> !busy;
    endproperty
    a_done_idle: assert property (p_done_idle)
        else $error("done asserted while busy");

    // Each result is shown for one cycle only.
    property p_done_pulse;
        @(posedge clk) disable iff (!rst_n) done |=> !done;
    endproperty
    a_done_pulse: assert property (p_done_pulse)
        else $error("done held for more than one cycle");

    // The loop only stops by delivering a result.
    property p_end_result;
        @(posedge clk) disable iff (!rst_n) $fell(busy) |-> done;
    endproperty
    a_end_result: assert property (p_end_result)
        else $error("busy fell without a result");

    // The result stays put while no new one is delivered, once one has been written.
    property p_result_hold;
        @(posedge clk) disable iff (!rst_n)
            (!done && !busy && !start && !$isunknown(divisor_out))
            |=> $stable(divisor_out);
    endproperty
    a_result_hold: assert property (p_result_hold)
        else $error("divisor_out changed while idle");

endmodule

bind euclid_gcd gcd_checker u_gcd_checker (.*);

@@ sim/tb_euclid_gcd.sv @@
`timescale 1ns / 1ps

module tb_euclid_gcd;

    localparam int GCD_W = 32;
    localparam int OW = gcd_pkg::OPERAND_W;
    localparam int RANDOM_PAIRS = 750;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam bit [OW-1:0] LANE_MASK = (GCD_W >= OW) ? '1 : ((OW'(1) << GCD_W) - 1);
    localparam bit [OW-1:0] ALL_ONES = '1;

    // One directed row: operands, and the divisor where it is plain to see.
    typedef struct {
        bit [OW-1:0] a;
        bit [OW-1:0] b;
        bit          known;
        bit [OW-1:0] want;
    } gcd_row_t;

    // One result still owed by the block.
    typedef struct {
        bit [OW-1:0] a;
        bit [OW-1:0] b;
        bit [OW-1:0] divisor;
    } gcd_owed_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [OW-1:0] operand_a;
    logic [OW-1:0] operand_b;
    logic          done;
    logic [OW-1:0] divisor_out;

    // Driver side copy of a typed-in divisor for the row being offered.
    bit            drv_known;
    bit [OW-1:0]   drv_want;

    gcd_owed_t     divisor_queue[$];
    int unsigned   err_count;
    int unsigned   idle_cycles;
    int unsigned   pairs_sent;
    int unsigned   results_checked;
    int unsigned   shared_factor_hits;
    int unsigned   zero_operand_hits;

    gcd_row_t directed_rows[] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{32'h0000_0000, 32'h0000_0005, 1'b1, 32'h0000_0005},
        '{32'h0000_0007, 32'h0000_0000, 1'b1, 32'h0000_0007},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000},
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0001},
        '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
        '{32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0001},
        '{32'd12,        32'd18,        1'b0, 32'h0},
        '{32'd18,        32'd12,        1'b0, 32'h0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h4000_0000, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h0000_0001, 1'b0, 32'h0},
        '{32'd2971215073, 32'd1836311903, 1'b0, 32'h0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0},
        '{32'hFFFF_0000, 32'h0000_FFFF, 1'b0, 32'h0},
        '{32'hFFFF_FFFE, 32'h0000_0002, 1'b0, 32'h0},
        '{32'd1000000007, 32'd998244353, 1'b0, 32'h0}
    };

    euclid_gcd #(
        .WIDTH(GCD_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .done(done),
        .divisor_out(divisor_out)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Euclidean reduction on the operands as the datapath sees them.
    function automatic bit [OW-1:0] gcd_of(input bit [OW-1:0] a, input bit [OW-1:0] b);
        bit [OW-1:0] big;
        bit [OW-1:0] little;
        bit [OW-1:0] rem;
        a = a & LANE_MASK;
        b = b & LANE_MASK;
        if (a == b)
            return a;
        if (a == 0)
            return b;
        if (b == 0)
            return a;
        big = (a > b) ? a : b;
        little = (a > b) ? b : a;
        rem = big % little;
        while (rem != 0)
        begin
            big = little;
            little = rem;
            rem = big % little;
        end
        return little;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // Offer one pair and hold it until an edge takes it; returns at the next falling edge.
    task automatic send_pair(input bit [OW-1:0] a, input bit [OW-1:0] b,
                             input bit known, input bit [OW-1:0] want);
        start = 1'b1;
        operand_a = a;
        operand_b = b;
        drv_known = known;
        drv_want = want;
        while (busy)
            @(negedge clk);
        @(negedge clk);
        pairs_sent++;
    endtask

    // Drop start for a number of cycles, with noise on the operand ports.
    task automatic idle_for(input int unsigned cycles);
        if (cycles > 0)
        begin
            start = 1'b0;
            operand_a = $urandom;
            operand_b = $urandom;
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic wait_for_drain();
        start = 1'b0;
        while (divisor_queue.size() != 0)
            @(negedge clk);
    endtask

    // Random pair biased toward shared factors, equal values and zeros.
    task automatic random_pair(output bit [OW-1:0] a, output bit [OW-1:0] b);
        bit [OW-1:0] factor;
        bit [OW-1:0] span;
        case ($urandom_range(9, 0))
            0, 1, 2, 3:
            begin
                a = $urandom;
                b = $urandom;
            end
            4, 5, 6:
            begin
                if ($urandom_range(1, 0))
                    factor = $urandom_range(65535, 1);
                else
                    factor = OW'(1) << $urandom_range(OW - 1, 0);
                span = ALL_ONES / factor;
                a = factor * $urandom_range(span, 1);
                b = factor * $urandom_range(span, 1);
            end
            7:
            begin
                a = $urandom;
                b = a;
            end
            8:
            begin
                a = $urandom;
                b = 0;
                if ($urandom_range(1, 0))
                begin
                    b = a;
                    a = 0;
                end
            end
            default:
            begin
                a = $urandom_range(255, 0) << $urandom_range(24, 0);
                b = $urandom_range(255, 0) << $urandom_range(24, 0);
            end
        endcase
    endtask

    // Monitor: take results against the oldest owed divisor, then log new transactions.
    always @(posedge clk)
    begin
        gcd_owed_t owed;
        bit        took;
        took = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                took = 1'b1;
                if (divisor_queue.size() == 0)
                    report_mismatch($sformatf("result %h with no transaction pending",
                                              divisor_out));
                else
                begin
                    owed = divisor_queue.pop_front();
                    results_checked++;
                    if (divisor_out !== owed.divisor)
                        report_mismatch($sformatf("gcd(%h, %h): divisor_out %h, wanted %h",
                                                  owed.a, owed.b, divisor_out, owed.divisor));
                end
            end
            if (start && !busy)
            begin
                took = 1'b1;
                owed.a = operand_a;
                owed.b = operand_b;
                owed.divisor = drv_known ? drv_want : gcd_of(operand_a, operand_b);
                if (owed.divisor > 1)
                    shared_factor_hits++;
                if ((operand_a & LANE_MASK) == 0 || (operand_b & LANE_MASK) == 0)
                    zero_operand_hits++;
                divisor_queue = {divisor_queue, owed};
            end
            idle_cycles = took ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any accepted transaction or result.
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Timeout after %0d quiet cycles, %0d results still owed",
                 idle_cycles, divisor_queue.size());
        $display("euclid_gcd test failed");
        $finish;
    end

    // Stimulus: reset, directed rows, then random bursts.
    initial
    begin
        bit [OW-1:0] a;
        bit [OW-1:0] b;
        int unsigned burst_len;
        rst_n = 1'b0;
        start = 1'b0;
        operand_a = '0;
        operand_b = '0;
        drv_known = 1'b0;
        drv_want = '0;
        err_count = 0;
        idle_cycles = 0;
        pairs_sent = 0;
        results_checked = 0;
        shared_factor_hits = 0;
        zero_operand_hits = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        // Directed rows go back to back.
        foreach (directed_rows[i])
            send_pair(directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].known, directed_rows[i].want);
        wait_for_drain();

        // Random bursts, with or without gaps; now and then the sender waits for a full drain.
        while (pairs_sent < directed_rows.size() + RANDOM_PAIRS)
        begin
            burst_len = $urandom_range(20, 1);
            repeat (burst_len)
            begin
                random_pair(a, b);
                send_pair(a, b, 1'b0, '0);
            end
            case ($urandom_range(9, 0))
                0:       wait_for_drain();
                1:       idle_for($urandom_range(80, 20));
                2, 3, 4: idle_for(0);
                default: idle_for($urandom_range(2 * GCD_W + 2, 1));
            endcase
        end

        // Let the last results arrive, then watch for strays.
        wait_for_drain();
        repeat (2 * GCD_W + 8) @(negedge clk);

        $display("Sent %0d operand pairs and checked %0d divisors", pairs_sent, results_checked);
        $display("Pairs with a shared factor: %0d, with a zero operand: %0d, mismatches: %0d",
                 shared_factor_hits, zero_operand_hits, err_count);
        if (err_count == 0 && divisor_queue.size() == 0)
            $display("euclid_gcd test passed");
        else
            $display("euclid_gcd test failed");
        $finish;
    end

endmodule
